/* hw/rtl/tcs_pkg.sv */
// Shared types and constants for the threshold city select block.
package tcs_pkg;

   // Fixed field widths of the transaction ports
   localparam int CITY_BITS       = 4;
   localparam int COUNT_BITS      = 4;
   localparam int EDGE_W_BITS     = 16;
   localparam int CITY_COUNT_BITS = 5;
   localparam int DIST_BITS       = 32;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 3;

   // Register indexes (byte address = 4 * index)
   localparam logic CSR_CITY_COUNT = 1'b0;
   localparam logic CSR_DIST_LIMIT = 1'b1;

   // Result of one edge relaxation
   typedef struct packed {
      logic                         update;
      logic signed [DIST_BITS-1:0]  cand;
   } tcs_eval_type;

endpackage

/* hw/rtl/tcs_relax_eval.sv */
// Edge relaxation: saturating distance add and improvement test.
module tcs_relax_eval
   import tcs_pkg::*;
#(
   parameter int WEIGHT_BITS = 16
) (
   input  logic                        present,
   input  logic [WEIGHT_BITS-1:0]      weight,
   input  logic signed [DIST_BITS-1:0] from_dist,
   input  logic signed [DIST_BITS-1:0] to_dist,
   input  logic                        to_known,
   output tcs_eval_type                result
);

   logic signed [DIST_BITS:0]   sum;
   logic signed [DIST_BITS-1:0] cand;

   assign sum = $signed({from_dist[DIST_BITS-1], from_dist})
              + $signed({{(DIST_BITS + 1 - WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight});

   // clamp to the 32-bit signed range on overflow
   always_comb begin
      if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
         cand = sum[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}}
                               : {1'b0, {(DIST_BITS-1){1'b1}}};
      end else begin
         cand = sum[DIST_BITS-1:0];
      end
   end

   assign result.cand   = cand;
   assign result.update = present && (!to_known || (to_dist > cand));

endmodule

/* hw/rtl/threshold_city_select.sv */
// Top level of the threshold city select block: edge table, sequencer, result register.
//
// Edges load one transaction per cycle into an edge memory of MAX_CITIES*MAX_CITIES
// words; a repeated (from, to) pair overwrites the earlier weight, and an edge whose
// city index is at or above MAX_CITIES is dropped. The transaction with last_edge set
// is stored and then starts the all-sources shortest path walk: for each source s of
// the n active cities the sequencer seeds the distance memory, runs n-1 passes over
// the rows of the edge memory (a row whose start city is still unreachable is passed
// over, any other row reads its start distance and then relaxes one edge per cycle
// through a one-stage read pipeline), then sweeps the distances once to count near
// cities, with bookkeeping states to seed each source and compare its count. The
// result transaction then goes to the output register, and a clearing pass over all
// MAX_CITIES*MAX_CITIES words empties the edge table; the same clearing pass runs
// after reset. If the previous result is still waiting in the output register, the
// walk holds before posting the new one. No edge is accepted during the walk or the
// clearing pass; a waiting result does not hold off edge loading. Distances saturate
// at the 32-bit signed range and negative cycles are not detected. Registers:
// city_count at 0x0 (0 acts as 1, above MAX_CITIES acts as MAX_CITIES),
// distance_limit at 0x4; write only while idle.
module threshold_city_select
   import tcs_pkg::*;
#(
   parameter int MAX_CITIES  = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // edge transactions
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [CITY_BITS-1:0]           req_from_city,
   input  logic [CITY_BITS-1:0]           req_to_city,
   input  logic signed [EDGE_W_BITS-1:0]  req_edge_weight,
   input  logic                           req_last_edge,
   // result transactions
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [CITY_BITS-1:0]           rsp_chosen_city,
   output logic [COUNT_BITS-1:0]          rsp_near_count,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                           csr_pready
);

   localparam int CW     = $clog2(MAX_CITIES);        // city index
   localparam int NW     = $clog2(MAX_CITIES + 1);    // city count / near count
   localparam int EDEPTH = MAX_CITIES * MAX_CITIES;
   localparam int AW     = $clog2(EDEPTH);
   localparam int EW     = WEIGHT_BITS + 1;           // {present, weight}

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRC_INIT, ST_ROW_RD, ST_ROW_CAP, ST_RELAX, ST_ROW_END,
      ST_COUNT, ST_COUNT_END, ST_SRC_DONE, ST_FINISH, ST_CLEAR
   } state_type;

   // ---------------- configuration registers ----------------
   logic [CITY_COUNT_BITS-1:0] city_count_ff;
   logic signed [DIST_BITS-1:0] dist_limit_ff;
   logic                        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CITY_COUNT_BITS'(16);
         dist_limit_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_CITY_COUNT: city_count_ff <= csr_pwdata[CITY_COUNT_BITS-1:0];
            CSR_DIST_LIMIT: dist_limit_ff <= $signed(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_CITY_COUNT: csr_prdata = CSR_DATA_BITS'(city_count_ff);
         CSR_DIST_LIMIT: csr_prdata = $unsigned(dist_limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // active city count, clamped to 1..MAX_CITIES
   logic [NW-1:0] n_act;
   logic [CW-1:0] n_last;

   always_comb begin
      if (city_count_ff == '0) begin
         n_act = NW'(1);
      end else if (int'(city_count_ff) > MAX_CITIES) begin
         n_act = NW'(MAX_CITIES);
      end else begin
         n_act = NW'(city_count_ff);
      end
   end
   assign n_last = CW'(n_act - NW'(1));

   // ---------------- memories ----------------
   logic [EW-1:0]               edge_mem [EDEPTH];
   logic [EW-1:0]               edge_q_ff;
   logic                        em_we;
   logic [AW-1:0]               em_waddr;
   logic [EW-1:0]               em_wdata;
   logic [AW-1:0]               em_raddr;

   logic signed [DIST_BITS-1:0] dist_mem [MAX_CITIES];
   logic signed [DIST_BITS-1:0] dist_q_ff;
   logic                        dm_we;
   logic [CW-1:0]               dm_waddr;
   logic signed [DIST_BITS-1:0] dm_wdata;
   logic [CW-1:0]               dm_raddr;

   always_ff @(posedge clock) begin
      if (em_we) begin
         edge_mem[em_waddr] <= em_wdata;
      end
      edge_q_ff <= edge_mem[em_raddr];
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dist_mem[dm_waddr] <= dm_wdata;
      end
      dist_q_ff <= dist_mem[dm_raddr];
   end

   // ---------------- sequencer state ----------------
   state_type                   state_ff, state_in;
   logic [CW-1:0]               src_ff, src_in;
   logic [CW-1:0]               pass_ff, pass_in;
   logic [CW-1:0]               f_ff, f_in;
   logic [CW-1:0]               t_ff, t_in;
   logic [MAX_CITIES-1:0]       known_ff, known_in;
   logic signed [DIST_BITS-1:0] df_ff, df_in;
   logic                        p_valid_ff, p_valid_in;   // read issued last cycle
   logic                        p_count_ff, p_count_in;   // that read is a count step
   logic [CW-1:0]               p_t_ff, p_t_in;
   logic [NW-1:0]               near_ff, near_in;
   logic [NW-1:0]               best_count_ff, best_count_in;
   logic [CW-1:0]               best_city_ff, best_city_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CITY_BITS-1:0]        rsp_city_ff, rsp_city_in;
   logic [COUNT_BITS-1:0]       rsp_count_ff, rsp_count_in;

   logic                        req_fire;
   logic                        edge_in_range;
   tcs_eval_type                relax;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign edge_in_range = (int'(req_from_city) < MAX_CITIES)
                       && (int'(req_to_city) < MAX_CITIES);

   tcs_relax_eval #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_relax_eval (
      .present   (edge_q_ff[EW-1]),
      .weight    (edge_q_ff[WEIGHT_BITS-1:0]),
      .from_dist (df_ff),
      .to_dist   (dist_q_ff),
      .to_known  (known_ff[p_t_ff]),
      .result    (relax)
   );

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      pass_in       = pass_ff;
      f_in          = f_ff;
      t_in          = t_ff;
      known_in      = known_ff;
      df_in         = df_ff;
      p_valid_in    = 1'b0;
      p_count_in    = p_count_ff;
      p_t_in        = p_t_ff;
      near_in       = near_ff;
      best_count_in = best_count_ff;
      best_city_in  = best_city_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_city_in   = rsp_city_ff;
      rsp_count_in  = rsp_count_ff;

      em_we    = 1'b0;
      em_waddr = AW'(req_from_city) * AW'(MAX_CITIES) + AW'(req_to_city);
      em_wdata = {1'b1, WEIGHT_BITS'($unsigned(req_edge_weight))};
      em_raddr = AW'(f_ff) * AW'(MAX_CITIES) + AW'(t_ff);
      dm_we    = 1'b0;
      dm_waddr = p_t_ff;
      dm_wdata = relax.cand;
      dm_raddr = t_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // read pipeline second half: evaluate the step issued last cycle
      if (p_valid_ff) begin
         if (p_count_ff) begin
            if ((p_t_ff != src_ff) && known_ff[p_t_ff] && (dist_q_ff <= dist_limit_ff)) begin
               near_in = near_ff + NW'(1);
            end
         end else if (relax.update) begin
            dm_we              = 1'b1;
            known_in[p_t_ff]   = 1'b1;
            if (p_t_ff == f_ff) begin
               df_in = relax.cand;   // self loop lowers the row's start distance
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               em_we = edge_in_range;
               if (req_last_edge) begin
                  src_in        = '0;
                  best_count_in = NW'(MAX_CITIES);
                  best_city_in  = '0;
                  state_in      = ST_SRC_INIT;
               end
            end
         end
         ST_SRC_INIT: begin
            dm_we    = 1'b1;
            dm_waddr = src_ff;
            dm_wdata = '0;
            known_in = '0;
            known_in[src_ff] = 1'b1;
            pass_in  = CW'(1);
            f_in     = '0;
            t_in     = '0;
            near_in  = '0;
            state_in = (n_act == NW'(1)) ? ST_COUNT : ST_ROW_RD;
         end
         ST_ROW_RD: begin
            dm_raddr = f_ff;
            if (known_ff[f_ff]) begin
               state_in = ST_ROW_CAP;
            end else if (f_ff != n_last) begin
               f_in = f_ff + CW'(1);
            end else if (pass_ff == n_last) begin
               t_in     = '0;
               state_in = ST_COUNT;
            end else begin
               pass_in = pass_ff + CW'(1);
               f_in    = '0;
            end
         end
         ST_ROW_CAP: begin
            df_in    = dist_q_ff;
            t_in     = '0;
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            p_valid_in = 1'b1;
            p_count_in = 1'b0;
            p_t_in     = t_ff;
            if (t_ff == n_last) begin
               state_in = ST_ROW_END;
            end else begin
               t_in = t_ff + CW'(1);
            end
         end
         ST_ROW_END: begin
            t_in = '0;
            if (f_ff != n_last) begin
               f_in     = f_ff + CW'(1);
               state_in = ST_ROW_RD;
            end else if (pass_ff == n_last) begin
               state_in = ST_COUNT;
            end else begin
               pass_in  = pass_ff + CW'(1);
               f_in     = '0;
               state_in = ST_ROW_RD;
            end
         end
         ST_COUNT: begin
            p_valid_in = 1'b1;
            p_count_in = 1'b1;
            p_t_in     = t_ff;
            if (t_ff == n_last) begin
               state_in = ST_COUNT_END;
            end else begin
               t_in = t_ff + CW'(1);
            end
         end
         ST_COUNT_END: begin
            state_in = ST_SRC_DONE;
         end
         ST_SRC_DONE: begin
            if (near_ff <= best_count_ff) begin
               best_count_in = near_ff;
               best_city_in  = src_ff;
            end
            if (src_ff == n_last) begin
               state_in = ST_FINISH;
            end else begin
               src_in   = src_ff + CW'(1);
               state_in = ST_SRC_INIT;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_city_in  = CITY_BITS'(best_city_ff);
               rsp_count_in = COUNT_BITS'(best_count_ff);
               clr_addr_in  = '0;
               state_in     = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            em_we    = 1'b1;
            em_waddr = clr_addr_ff;
            em_wdata = '0;
            if (clr_addr_ff == AW'(EDEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         src_ff        <= '0;
         pass_ff       <= '0;
         f_ff          <= '0;
         t_ff          <= '0;
         known_ff      <= '0;
         p_valid_ff    <= 1'b0;
         p_count_ff    <= 1'b0;
         p_t_ff        <= '0;
         near_ff       <= '0;
         best_count_ff <= NW'(MAX_CITIES);
         best_city_ff  <= '0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         src_ff        <= src_in;
         pass_ff       <= pass_in;
         f_ff          <= f_in;
         t_ff          <= t_in;
         known_ff      <= known_in;
         p_valid_ff    <= p_valid_in;
         p_count_ff    <= p_count_in;
         p_t_ff        <= p_t_in;
         near_ff       <= near_in;
         best_count_ff <= best_count_in;
         best_city_ff  <= best_city_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload registers
      df_ff        <= df_in;
      rsp_city_ff  <= rsp_city_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_city = rsp_city_ff;
   assign rsp_near_count  = rsp_count_ff;

endmodule

/* verif/threshold_city_select_test.sv */
// Self-checking testbench for threshold_city_select: edge loading, all-sources walk, result check.
module threshold_city_select_test;
   import tcs_pkg::*;

   localparam int MAX_CITIES     = 16;
   localparam int WEIGHT_BITS    = 16;
   localparam int CLK_PERIOD     = 8;
   // clearing pass of the edge table plus margin; also the hold-off before any register write
   localparam int SETTLE_CYCLES  = MAX_CITIES * MAX_CITIES + 44;
   // watchdog limit, several times the worst single walk at 16 cities
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int RANDOM_ITEMS   = 1980;
   localparam int BACKPRESSURE_CYCLES = 4000;
   localparam int DIST_MAX       = 32'sh7fff_ffff;
   localparam int DIST_MIN       = -32'sh7fff_ffff - 1;

   // one expected result transaction
   typedef struct packed {
      logic [CITY_BITS-1:0]  city;
      logic [COUNT_BITS-1:0] near;
   } choice_type;

   // ---------------------------------------------------------------- DUT ports
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [CITY_BITS-1:0]          req_from_city = '0;
   logic [CITY_BITS-1:0]          req_to_city = '0;
   logic signed [EDGE_W_BITS-1:0] req_edge_weight = '0;
   logic                          req_last_edge = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [CITY_BITS-1:0]          rsp_chosen_city;
   logic [COUNT_BITS-1:0]         rsp_near_count;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      csr_prdata;
   logic                          csr_pready;

   // ---------------------------------------------------------------- predictor state
   // Edge table as the block should hold it; weights only read where edge_set is high.
   logic signed [EDGE_W_BITS-1:0] edge_wt [MAX_CITIES*MAX_CITIES];
   bit                            edge_set [MAX_CITIES*MAX_CITIES] = '{default: 1'b0};
   logic [CITY_COUNT_BITS-1:0]    cfg_city_count = 5'd16;
   int                            cfg_limit = 0;

   choice_type pending_choices [$];
   choice_type head_choice;

   int  mismatches = 0;
   int  results_seen = 0;
   int  edges_sent = 0;
   int  quiet_cycles = 0;
   // idling controls, flipped by the tests
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   // receiver hold-off: a test posts a request, the receiver process counts it down
   int  hold_request = 0;
   int  hold_left = 0;

   threshold_city_select #(
      .MAX_CITIES  (MAX_CITIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_from_city   (req_from_city),
      .req_to_city     (req_to_city),
      .req_edge_weight (req_edge_weight),
      .req_last_edge   (req_last_edge),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_chosen_city (rsp_chosen_city),
      .rsp_near_count  (rsp_near_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
   endtask

   // city_count as the block uses it: 0 acts as 1, above MAX_CITIES acts as MAX_CITIES
   function automatic int active_cities();
      int n;
      n = int'(cfg_city_count);
      if (n == 0) n = 1;
      if (n > MAX_CITIES) n = MAX_CITIES;
      return n;
   endfunction

   // All-sources Bellman-Ford over the present edges; fewest near cities wins,
   // highest index on a tie.
   function automatic choice_type choose_city();
      int      n, src, pass, f, t, idx, near, best_near, best_src, cand;
      int      path_len [MAX_CITIES];
      bit      known [MAX_CITIES];
      longint  sum;
      choice_type r;
      n = active_cities();
      best_near = MAX_CITIES;
      best_src = 0;
      for (src = 0; src < n; src++) begin
         for (t = 0; t < MAX_CITIES; t++) begin
            path_len[t] = 0;
            known[t] = 1'b0;
         end
         known[src] = 1'b1;
         for (pass = 1; pass < n; pass++) begin
            for (f = 0; f < n; f++) begin
               for (t = 0; t < n; t++) begin
                  idx = f * MAX_CITIES + t;
                  if (edge_set[idx] && known[f]) begin
                     // saturating sum at 32-bit signed
                     sum = longint'(path_len[f]) + longint'(edge_wt[idx]);
                     if (sum > longint'(DIST_MAX)) cand = DIST_MAX;
                     else if (sum < longint'(DIST_MIN)) cand = DIST_MIN;
                     else cand = int'(sum);
                     // unreachable target always takes the candidate
                     if (!known[t] || path_len[t] > cand) begin
                        path_len[t] = cand;
                        known[t] = 1'b1;
                     end
                  end
               end
            end
         end
         // source itself and unreachable cities never count
         near = 0;
         for (t = 0; t < n; t++)
            if (t != src && known[t] && path_len[t] <= cfg_limit) near++;
         if (near <= best_near) begin
            best_near = near;
            best_src = src;
         end
      end
      r.city = best_src[CITY_BITS-1:0];
      r.near = best_near[COUNT_BITS-1:0];
      return r;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap(input bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------- edge sender
   // Offers one edge transaction and updates the predictor when it is accepted.
   // valid stays high after acceptance so that a following call in the same step
   // can present the next edge without a bubble.
   task automatic send_edge(input int f, input int t,
                            input logic signed [EDGE_W_BITS-1:0] w, input bit last);
      int gap, idx;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_from_city   <= f[CITY_BITS-1:0];
      req_to_city     <= t[CITY_BITS-1:0];
      req_edge_weight <= w;
      req_last_edge   <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      edges_sent++;
      if (f < MAX_CITIES && t < MAX_CITIES) begin
         idx = f * MAX_CITIES + t;
         edge_wt[idx] = w;
         edge_set[idx] = 1'b1;
      end
      if (last) begin
         // last edge is stored first, then the walk; table empties afterwards
         pending_choices = {pending_choices, choose_city()};
         edge_set = '{default: 1'b0};
      end
   endtask

   // Drop valid and wait for every outstanding result transaction.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- register access
   // Hold-off first (covers the clearing pass), then write, then read back.
   task automatic set_register(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback, want_rd;
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == CSR_CITY_COUNT) begin
         cfg_city_count = value[CITY_COUNT_BITS-1:0];
         want_rd = CSR_DATA_BITS'(value[CITY_COUNT_BITS-1:0]);
      end else begin
         cfg_limit = int'(value);
         want_rd = value;
      end
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== want_rd)
         report_mismatch($sformatf("register %0d read 0x%08h, wrote 0x%08h",
                                   idx, readback, want_rd));
   endtask

   task automatic configure(input logic [CITY_COUNT_BITS-1:0] cities,
                            input logic [CSR_DATA_BITS-1:0] limit);
      set_register(CSR_CITY_COUNT, CSR_DATA_BITS'(cities));
      set_register(CSR_DIST_LIMIT, limit);
   endtask

   // One well-formed graph: edges mostly among the active cities, some noise
   // outside them, last edge flagged.
   task automatic send_random_graph(input int n);
      int edges, k, f, t, r, top;
      logic signed [EDGE_W_BITS-1:0] w;
      top = (n * n + 2 > 24) ? 24 : n * n + 2;
      edges = $urandom_range(1, top);
      for (k = 0; k < edges; k++) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            f = $urandom_range(0, n - 1);
            t = $urandom_range(0, n - 1);
         end else begin
            f = $urandom_range(0, MAX_CITIES - 1);
            t = $urandom_range(0, MAX_CITIES - 1);
         end
         r = $urandom_range(0, 99);
         if (r < 60) w = EDGE_W_BITS'($urandom_range(0, 80) - 15);
         else if (r < 85) w = EDGE_W_BITS'($urandom);
         else if (r < 93) w = 16'sh7fff;
         else w = 16'sh8000;
         send_edge(f, t, w, k == edges - 1);
      end
   endtask

   // ---------------------------------------------------------------- tests
   // A single active city has no passes: city 0, count 0. Count 0 acts as 1.
   task automatic test_single_city();
      configure(5'd1, 32'd0);
      send_edge(0, 1, 16'sd5, 1'b0);
      send_edge(1, 0, -16'sd3, 1'b1);
      wait_for_results();
      configure(5'd0, 32'd100);
      send_edge(15, 15, 16'sh8000, 1'b1);
      wait_for_results();
   endtask

   // Weight extremes, overwrite of a repeated pair, negative self-loop,
   // edges touching inactive cities, an unreachable city.
   task automatic test_weight_extremes();
      configure(5'd4, 32'd10);
      send_edge(0, 1, 16'sh7fff, 1'b0);
      send_edge(0, 2, 16'sh8000, 1'b0);
      send_edge(1, 2, 16'sd7, 1'b0);
      send_edge(0, 1, 16'sd3, 1'b0);
      send_edge(2, 2, -16'sd1, 1'b0);
      send_edge(9, 3, 16'sd1, 1'b0);
      send_edge(3, 9, 16'sd1, 1'b0);
      send_edge(2, 3, 16'sd10, 1'b1);
      wait_for_results();
   endtask

   // Limit at both ends; count above MAX_CITIES acts as MAX_CITIES.
   task automatic test_limit_extremes();
      configure(5'd31, 32'h7fff_ffff);
      send_edge(0, 15, 16'sd100, 1'b0);
      send_edge(15, 7, -16'sd5, 1'b0);
      send_edge(7, 0, 16'sd2, 1'b1);
      wait_for_results();
      configure(5'd5, 32'h8000_0000);
      send_edge(0, 1, 16'sh8000, 1'b0);
      send_edge(1, 2, 16'sh8000, 1'b0);
      send_edge(2, 3, 16'sh8000, 1'b0);
      send_edge(3, 4, 16'sh8000, 1'b1);
      wait_for_results();
   endtask

   // Receiver holds off while three graphs go in back to back: the first result
   // parks in the output register, the second walk cannot drain, edge input stalls.
   task automatic test_output_backpressure();
      configure(5'd3, 32'd20);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_request = BACKPRESSURE_CYCLES;
      repeat (3) send_random_graph(3);
      wait_for_results();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Random graphs under random settings; small city counts dominate since the
   // walk grows with the fourth power of the count, large ones get one graph each.
   task automatic test_random_graphs();
      int start, r, graphs, cities;
      logic [CSR_DATA_BITS-1:0] limit;
      start = edges_sent;
      while (edges_sent - start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         graphs = $urandom_range(2, 6);
         if (r < 60) cities = $urandom_range(2, 6);
         else if (r < 82) cities = $urandom_range(7, 10);
         else if (r < 92) cities = $urandom_range(0, 1);
         else if (r < 97) begin
            cities = $urandom_range(11, 15);
            graphs = 1;
         end else begin
            cities = $urandom_range(16, 31);
            graphs = 1;
         end
         r = $urandom_range(0, 99);
         if (r < 50) limit = $urandom_range(0, 160) - 20;
         else if (r < 62) limit = '0;
         else if (r < 72) limit = 32'h7fff_ffff;
         else if (r < 82) limit = 32'h8000_0000;
         else limit = $urandom;
         configure(cities[CITY_COUNT_BITS-1:0], limit);
         repeat (graphs) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            send_random_graph(active_cities());
         end
         wait_for_results();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- receiver
   // rsp_ready: forced low during a posted hold-off, otherwise random with
   // occasional long stalls, or held high when idling is off.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!rsp_idle_on) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
         hold_left = $urandom_range(20, 80);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // ---------------------------------------------------------------- result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_choices.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
         end else begin
            head_choice = pending_choices.pop_front();
            if (rsp_chosen_city !== head_choice.city)
               report_mismatch($sformatf("result %0d chosen_city %0d, predicted %0d",
                                         results_seen, rsp_chosen_city, head_choice.city));
            if (rsp_near_count !== head_choice.near)
               report_mismatch($sformatf("result %0d near_count %0d, predicted %0d",
                                         results_seen, rsp_near_count, head_choice.near));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   // counts cycles with no transaction on any port
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("threshold_city_select test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_single_city();
      test_weight_extremes();
      test_limit_extremes();
      test_output_backpressure();
      test_random_graphs();
      // random test ends drained; let the last clearing pass finish
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_choices.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_choices.size()));
      if (mismatches == 0)
         $display("threshold_city_select test passed");
      else
         $display("threshold_city_select test failed");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_relax_eval.sv
hw/rtl/threshold_city_select.sv
verif/threshold_city_select_test.sv
